>>> rtl/um32_pkg.sv
// Package for the UM-32 execute core: word width, opcode and request codes,
// item kinds, controller states and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package um32_pkg;

  localparam int WORD_W  = 32;
  localparam int REG_N   = 8;
  localparam int RIDX_W  = $clog2(REG_N);
  localparam int REQ_W   = 4;
  localparam int OPC_W   = 4;
  localparam int IMM_W   = 25;

  typedef enum logic [OPC_W-1:0] {
    OP_CMOV  = 4'd0,
    OP_READ  = 4'd1,
    OP_WRITE = 4'd2,
    OP_ADD   = 4'd3,
    OP_MUL   = 4'd4,
    OP_DIV   = 4'd5,
    OP_NAND  = 4'd6,
    OP_HALT  = 4'd7,
    OP_MAP   = 4'd8,
    OP_UNMAP = 4'd9,
    OP_OUT   = 4'd10,
    OP_IN    = 4'd11,
    OP_LOAD  = 4'd12,
    OP_LIMM  = 4'd13
  } op_e;

  typedef enum logic [REQ_W-1:0] {
    REQ_NONE  = 4'd0,
    REQ_READ  = 4'd1,
    REQ_WRITE = 4'd2,
    REQ_MAP   = 4'd3,
    REQ_UNMAP = 4'd4,
    REQ_OUT   = 4'd5,
    REQ_IN    = 4'd6,
    REQ_LOAD  = 4'd7,
    REQ_HALT  = 4'd8,
    REQ_DIVF  = 4'd9
  } req_e;

  typedef enum logic {
    KIND_INSTR = 1'b0,
    KIND_FILL  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDA,
    ST_EXEC,
    ST_DIV,
    ST_WB
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic read_a;
    logic div_start;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_a;
    logic div_needed;
    logic div_done;
  } dp_status_t;

endpackage

>>> rtl/um32_div.sv
// Radix-2 restoring divider for the UM-32 execute core, one quotient bit per cycle.
// Depends on um32_pkg.
`timescale 1ns / 1ps

module um32_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [um32_pkg::WORD_W-1:0] dividend_i,
  input  logic [um32_pkg::WORD_W-1:0] divisor_i,
  output logic [um32_pkg::WORD_W-1:0] quotient_o,
  output logic                        done_o
);
  import um32_pkg::*;

  localparam int CntW = $clog2(WORD_W);

  logic [WORD_W-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [WORD_W:0]   shifted, diff;

  always_comb begin
    shifted = {rem_q, quo_q[WORD_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[WORD_W]) begin
        rem_d = diff[WORD_W-1:0];
        quo_d = {quo_q[WORD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[WORD_W-1:0];
        quo_d = {quo_q[WORD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(WORD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

>>> rtl/um32_ctrl.sv
// Controller state machine of the UM-32 execute core: input and output handshakes,
// register read sequencing, divider start and commit. Depends on um32_pkg.
`timescale 1ns / 1ps

module um32_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  um32_pkg::dp_status_t   status_i,
  output um32_pkg::ctrl_cmd_t    cmd_o
);
  import um32_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = status_i.need_a ? ST_RDA : ST_EXEC;
        end
      end
      ST_RDA: begin
        cmd_o.read_a = 1'b1;
        state_d      = ST_EXEC;
      end
      ST_EXEC: begin
        if (status_i.div_needed) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/um32_dp.sv
// Datapath of the UM-32 execute core: register file memory, machine state,
// instruction execution and the output register. Depends on um32_pkg and um32_div.
`timescale 1ns / 1ps

module um32_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  um32_pkg::ctrl_cmd_t         cmd_i,
  output um32_pkg::dp_status_t        status_o,
  input  logic                        in_opcode_i,
  input  logic [um32_pkg::WORD_W-1:0] in_instruction_i,
  input  logic [um32_pkg::WORD_W-1:0] in_fill_data_i,
  output logic [um32_pkg::REQ_W-1:0]  out_request_o,
  output logic [um32_pkg::WORD_W-1:0] out_seg_id_o,
  output logic [um32_pkg::WORD_W-1:0] out_word_offset_o,
  output logic [um32_pkg::WORD_W-1:0] out_write_data_o,
  output logic [um32_pkg::WORD_W-1:0] out_fetch_pc_o,
  output logic                        out_awaiting_fill_o,
  output logic                        out_halted_o
);
  import um32_pkg::*;

  logic [WORD_W-1:0] rf_mem [REG_N];
  logic [REG_N-1:0]  rf_valid_q;

  logic [WORD_W-1:0] ins_q, fdat_q;
  logic              kind_q;
  logic [WORD_W-1:0] rd0_q, rd1_q, rb_hold_q;
  logic              rd0_v_q, rd1_v_q;
  logic              re0, re1;
  logic [RIDX_W-1:0] ra0, ra1;

  logic [WORD_W-1:0] pc_q, pc_d;
  logic              halt_q, halt_d, pend_q, pend_d;
  logic [RIDX_W-1:0] tgt_q, tgt_d;

  logic [WORD_W-1:0] v0, rc_v, rb_v, prod, quot;
  op_e               op;
  logic              exec_ok;
  logic              div_done;

  logic              rf_we;
  logic [RIDX_W-1:0] rf_wa;
  logic [WORD_W-1:0] rf_wd;
  req_e              req;
  logic [WORD_W-1:0] sid, off, wdat;

  logic [REQ_W-1:0]  req_q;
  logic [WORD_W-1:0] sid_q, off_q, wdat_q, opc_q;
  logic              opend_q, ohalt_q;

  assign re0 = cmd_i.accept || cmd_i.read_a;
  assign re1 = cmd_i.accept;
  assign ra0 = cmd_i.read_a ? ins_q[8:6] : in_instruction_i[5:3];
  assign ra1 = in_instruction_i[2:0];

  always_ff @(posedge clk_i) begin
    if (rf_we && cmd_i.commit) begin
      rf_mem[rf_wa] <= rf_wd;
    end
    if (re0) begin
      rd0_q <= rf_mem[ra0];
    end
    if (re1) begin
      rd1_q <= rf_mem[ra1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_valid_q <= '0;
      rd0_v_q    <= 1'b0;
      rd1_v_q    <= 1'b0;
    end else begin
      if (rf_we && cmd_i.commit) begin
        rf_valid_q[rf_wa] <= 1'b1;
      end
      if (re0) begin
        rd0_v_q <= rf_valid_q[ra0];
      end
      if (re1) begin
        rd1_v_q <= rf_valid_q[ra1];
      end
    end
  end

  assign v0   = rd0_v_q ? rd0_q : '0;
  assign rc_v = rd1_v_q ? rd1_q : '0;
  assign op   = op_e'(ins_q[WORD_W-1 -: OPC_W]);
  assign rb_v = (op == OP_WRITE) ? rb_hold_q : v0;
  assign prod = rb_v * rc_v;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= in_opcode_i;
      ins_q  <= in_instruction_i;
      fdat_q <= in_fill_data_i;
    end
    if (cmd_i.read_a) begin
      rb_hold_q <= v0;
    end
  end

  um32_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rb_v),
    .divisor_i  (rc_v),
    .quotient_o (quot),
    .done_o     (div_done)
  );

  assign exec_ok = !halt_q && (kind_q == KIND_INSTR) && !pend_q;

  assign status_o.need_a     = (in_opcode_i == KIND_INSTR) &&
                               (in_instruction_i[WORD_W-1 -: OPC_W] == OP_WRITE);
  assign status_o.div_needed = exec_ok && (op == OP_DIV) && (rc_v != '0);
  assign status_o.div_done   = div_done;

  always_comb begin
    req   = REQ_NONE;
    sid   = '0;
    off   = '0;
    wdat  = '0;
    pc_d  = pc_q;
    halt_d = halt_q;
    pend_d = pend_q;
    tgt_d = tgt_q;
    rf_we = 1'b0;
    rf_wa = ins_q[8:6];
    rf_wd = '0;
    if (!halt_q) begin
      if (kind_q == KIND_FILL) begin
        if (pend_q) begin
          rf_we  = 1'b1;
          rf_wa  = tgt_q;
          rf_wd  = fdat_q;
          pend_d = 1'b0;
        end
      end else if (!pend_q) begin
        pc_d = pc_q + 1'b1;
        unique case (op)
          OP_CMOV: begin
            rf_we = (rc_v != '0);
            rf_wd = rb_v;
          end
          OP_READ: begin
            req    = REQ_READ;
            sid    = rb_v;
            off    = rc_v;
            pend_d = 1'b1;
            tgt_d  = ins_q[8:6];
          end
          OP_WRITE: begin
            req  = REQ_WRITE;
            sid  = v0;
            off  = rb_hold_q;
            wdat = rc_v;
          end
          OP_ADD: begin
            rf_we = 1'b1;
            rf_wd = rb_v + rc_v;
          end
          OP_MUL: begin
            rf_we = 1'b1;
            rf_wd = prod;
          end
          OP_DIV: begin
            if (rc_v == '0) begin
              req = REQ_DIVF;
            end else begin
              rf_we = 1'b1;
              rf_wd = quot;
            end
          end
          OP_NAND: begin
            rf_we = 1'b1;
            rf_wd = ~(rb_v & rc_v);
          end
          OP_HALT: begin
            req    = REQ_HALT;
            halt_d = 1'b1;
          end
          OP_MAP: begin
            req    = REQ_MAP;
            wdat   = rc_v;
            pend_d = 1'b1;
            tgt_d  = ins_q[5:3];
          end
          OP_UNMAP: begin
            req = REQ_UNMAP;
            sid = rc_v;
          end
          OP_OUT: begin
            req  = REQ_OUT;
            wdat = rc_v;
          end
          OP_IN: begin
            req    = REQ_IN;
            pend_d = 1'b1;
            tgt_d  = ins_q[2:0];
          end
          OP_LOAD: begin
            req  = REQ_LOAD;
            sid  = rb_v;
            pc_d = rc_v;
          end
          OP_LIMM: begin
            rf_we = 1'b1;
            rf_wa = ins_q[27:25];
            rf_wd = {{(WORD_W-IMM_W){1'b0}}, ins_q[IMM_W-1:0]};
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      halt_q <= 1'b0;
      pend_q <= 1'b0;
      tgt_q  <= '0;
    end else if (cmd_i.commit) begin
      pc_q   <= pc_d;
      halt_q <= halt_d;
      pend_q <= pend_d;
      tgt_q  <= tgt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      req_q   <= req;
      sid_q   <= sid;
      off_q   <= off;
      wdat_q  <= wdat;
      opc_q   <= pc_d;
      opend_q <= pend_d;
      ohalt_q <= halt_d;
    end
  end

  assign out_request_o       = req_q;
  assign out_seg_id_o        = sid_q;
  assign out_word_offset_o   = off_q;
  assign out_write_data_o    = wdat_q;
  assign out_fetch_pc_o      = opc_q;
  assign out_awaiting_fill_o = opend_q;
  assign out_halted_o        = ohalt_q;

endmodule

>>> rtl/um32_instruction_execute_core.sv
// Top level of the UM-32 execute core: joins the controller and the datapath.
// Depends on um32_pkg, um32_ctrl, um32_dp and um32_div.
//
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_stall_o   opcode, instruction, fill_data
// out      output     out_valid_o/out_stall_i request, seg_id, word_offset, write_data,
//                                             fetch_pc, awaiting_fill, halted
//
// One item is worked on at a time. Most items pass through accept and execute;
// a write request adds a register read step, since the register file has two read ports.
// A divide with a nonzero divisor waits for the bit-serial divider, then writes back.
// A stalled output holds the next commit until the waiting result is taken.
// Reset clears all registers, the program counter and the halt and fill marks.
`timescale 1ns / 1ps

module um32_instruction_execute_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        in_opcode_i,
  input  logic [um32_pkg::WORD_W-1:0] in_instruction_i,
  input  logic [um32_pkg::WORD_W-1:0] in_fill_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [um32_pkg::REQ_W-1:0]  out_request_o,
  output logic [um32_pkg::WORD_W-1:0] out_seg_id_o,
  output logic [um32_pkg::WORD_W-1:0] out_word_offset_o,
  output logic [um32_pkg::WORD_W-1:0] out_write_data_o,
  output logic [um32_pkg::WORD_W-1:0] out_fetch_pc_o,
  output logic                        out_awaiting_fill_o,
  output logic                        out_halted_o
);
  import um32_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  um32_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  um32_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .in_opcode_i         (in_opcode_i),
    .in_instruction_i    (in_instruction_i),
    .in_fill_data_i      (in_fill_data_i),
    .out_request_o       (out_request_o),
    .out_seg_id_o        (out_seg_id_o),
    .out_word_offset_o   (out_word_offset_o),
    .out_write_data_o    (out_write_data_o),
    .out_fetch_pc_o      (out_fetch_pc_o),
    .out_awaiting_fill_o (out_awaiting_fill_o),
    .out_halted_o        (out_halted_o)
  );

endmodule

>>> rtl/um32_checker.sv
// Port-level checker for the UM-32 execute core and its bind to the top level.
// Depends on um32_pkg.
`timescale 1ns / 1ps

module um32_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [um32_pkg::REQ_W-1:0]  out_request_o,
  input logic [um32_pkg::WORD_W-1:0] out_seg_id_o,
  input logic [um32_pkg::WORD_W-1:0] out_word_offset_o,
  input logic [um32_pkg::WORD_W-1:0] out_write_data_o,
  input logic [um32_pkg::WORD_W-1:0] out_fetch_pc_o,
  input logic                        out_awaiting_fill_o,
  input logic                        out_halted_o
);
  import um32_pkg::*;

  // A stalled result stays valid and keeps its request, fetch PC and segment id.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_request_o) &&
      $stable(out_fetch_pc_o) && $stable(out_seg_id_o))
    else $error("stalled result changed");

  // The core takes one request at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while busy");

  // A halted core reports nothing but the halt itself.
  a_halted_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_halted_o && (out_request_o != REQ_HALT) |->
      (out_request_o == REQ_NONE) && (out_seg_id_o == '0) &&
      (out_word_offset_o == '0) && (out_write_data_o == '0))
    else $error("halted core issued a request");

  // Read, map and input requests leave the core waiting for a fill.
  a_fill_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_request_o == REQ_READ) || (out_request_o == REQ_MAP) ||
      (out_request_o == REQ_IN)) |-> out_awaiting_fill_o && !out_halted_o)
    else $error("fill request without pending fill");

endmodule

bind um32_instruction_execute_core um32_checker u_um32_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_stall_o          (in_stall_o),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .out_request_o       (out_request_o),
  .out_seg_id_o        (out_seg_id_o),
  .out_word_offset_o   (out_word_offset_o),
  .out_write_data_o    (out_write_data_o),
  .out_fetch_pc_o      (out_fetch_pc_o),
  .out_awaiting_fill_o (out_awaiting_fill_o),
  .out_halted_o        (out_halted_o)
);

>>> bench/um32_instruction_execute_core_tb.sv
// Self-checking testbench for um32_instruction_execute_core: a directed table, then random
// instruction streams with fill returns, checked against a cycle-free model of the core.
// Depends on um32_pkg and the RTL of the core only.
`timescale 1ns / 1ps

module um32_instruction_execute_core_tb;
  import um32_pkg::*;

  localparam int ITEM_COUNT    = 1900;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int DIRECTED_N    = 25;

  typedef struct packed {
    req_e        request;
    logic [31:0] seg_id, word_offset, write_data, fetch_pc;
    logic        awaiting_fill, halted;
  } um_result_t;

  typedef struct {
    kind_e       kind;
    logic [31:0] word;
    logic [31:0] fill;
    logic        pinned;
    um_result_t  want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        in_opcode_i;
  logic [31:0] in_instruction_i;
  logic [31:0] in_fill_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  out_request_o;
  logic [31:0] out_seg_id_o;
  logic [31:0] out_word_offset_o;
  logic [31:0] out_write_data_o;
  logic [31:0] out_fetch_pc_o;
  logic        out_awaiting_fill_o;
  logic        out_halted_o;

  logic [31:0] model_regs [8];
  logic [31:0] model_pc;
  logic        model_halted;
  logic        model_pending;
  logic [2:0]  model_target;

  um_result_t  expected_results [$];
  stim_row_t   directed_rows [DIRECTED_N];
  int          mismatches;
  bit          steady;

  um32_instruction_execute_core u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_opcode_i        (in_opcode_i),
    .in_instruction_i   (in_instruction_i),
    .in_fill_data_i     (in_fill_data_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_request_o      (out_request_o),
    .out_seg_id_o       (out_seg_id_o),
    .out_word_offset_o  (out_word_offset_o),
    .out_write_data_o   (out_write_data_o),
    .out_fetch_pc_o     (out_fetch_pc_o),
    .out_awaiting_fill_o(out_awaiting_fill_o),
    .out_halted_o       (out_halted_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] abc_word(op_e op, logic [2:0] a, logic [2:0] b,
                                           logic [2:0] c);
    return {op, 19'b0, a, b, c};
  endfunction

  function automatic um_result_t pinned_result(req_e req, logic [31:0] seg, logic [31:0] off,
                                               logic [31:0] wdat, logic [31:0] pc,
                                               logic awaiting);
    um_result_t res;
    res = '0;
    res.request       = req;
    res.seg_id        = seg;
    res.word_offset   = off;
    res.write_data    = wdat;
    res.fetch_pc      = pc;
    res.awaiting_fill = awaiting;
    return res;
  endfunction

  function automatic logic [31:0] pick_fill();
    case ($urandom_range(7))
      0: return '1;
      1: return 32'($urandom_range(15));
      default: return $urandom();
    endcase
  endfunction

  // Executes one request against the model state and returns the result it causes.
  function automatic um_result_t execute_item(kind_e kind, logic [31:0] word,
                                              logic [31:0] fill);
    um_result_t  res;
    logic [2:0]  a, b, c;
    logic [31:0] ra, rb, rc, next_pc;
    res = '0;
    a = word[8:6];
    b = word[5:3];
    c = word[2:0];
    ra = model_regs[a];
    rb = model_regs[b];
    rc = model_regs[c];
    next_pc = model_pc + 32'd1;
    if (!model_halted) begin
      if (kind == KIND_FILL) begin
        if (model_pending) begin
          model_regs[model_target] = fill;
          model_pending = 1'b0;
        end
      end else if (!model_pending) begin
        case (word[31:28])
          OP_CMOV: if (rc != 32'd0) model_regs[a] = rb;
          OP_READ: begin
            res.request = REQ_READ;
            res.seg_id = rb;
            res.word_offset = rc;
            model_pending = 1'b1;
            model_target = a;
          end
          OP_WRITE: begin
            res.request = REQ_WRITE;
            res.seg_id = ra;
            res.word_offset = rb;
            res.write_data = rc;
          end
          OP_ADD: model_regs[a] = rb + rc;
          OP_MUL: model_regs[a] = rb * rc;
          OP_DIV: begin
            if (rc == 32'd0) res.request = REQ_DIVF;
            else model_regs[a] = rb / rc;
          end
          OP_NAND: model_regs[a] = ~(rb & rc);
          OP_HALT: begin
            res.request = REQ_HALT;
            model_halted = 1'b1;
          end
          OP_MAP: begin
            res.request = REQ_MAP;
            res.write_data = rc;
            model_pending = 1'b1;
            model_target = b;
          end
          OP_UNMAP: begin
            res.request = REQ_UNMAP;
            res.seg_id = rc;
          end
          OP_OUT: begin
            res.request = REQ_OUT;
            res.write_data = rc;
          end
          OP_IN: begin
            res.request = REQ_IN;
            model_pending = 1'b1;
            model_target = c;
          end
          OP_LOAD: begin
            res.request = REQ_LOAD;
            res.seg_id = rb;
            next_pc = rc;
          end
          OP_LIMM: model_regs[word[27:25]] = {7'b0, word[24:0]};
          default: ;
        endcase
        model_pc = next_pc;
      end
    end
    res.fetch_pc      = model_pc;
    res.awaiting_fill = model_pending;
    res.halted        = model_halted;
    return res;
  endfunction

  task automatic send_request(kind_e kind, logic [31:0] word, logic [31:0] fill,
                              logic pinned, um_result_t pinned_res);
    um_result_t res;
    res = execute_item(kind, word, fill);
    expected_results.push_back(pinned ? pinned_res : res);
    while (!steady && ($urandom_range(99) < 36)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    in_opcode_i      <= kind;
    in_instruction_i <= word;
    in_fill_data_i   <= fill;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  initial begin
    um_result_t want;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unrequested result, request", 32'(out_request_o), '0);
        end else begin
          want = expected_results.pop_front();
          if (out_request_o !== want.request)
            report_mismatch("request", 32'(out_request_o), 32'(want.request));
          if (out_seg_id_o !== want.seg_id)
            report_mismatch("seg_id", out_seg_id_o, want.seg_id);
          if (out_word_offset_o !== want.word_offset)
            report_mismatch("word_offset", out_word_offset_o, want.word_offset);
          if (out_write_data_o !== want.write_data)
            report_mismatch("write_data", out_write_data_o, want.write_data);
          if (out_fetch_pc_o !== want.fetch_pc)
            report_mismatch("fetch_pc", out_fetch_pc_o, want.fetch_pc);
          if (out_awaiting_fill_o !== want.awaiting_fill)
            report_mismatch("awaiting_fill", 32'(out_awaiting_fill_o),
                            32'(want.awaiting_fill));
          if (out_halted_o !== want.halted)
            report_mismatch("halted", 32'(out_halted_o), 32'(want.halted));
        end
      end
      out_stall_i <= !steady && ($urandom_range(99) < 36);
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int          useful;
    logic [3:0]  op;
    kind_e       kind;
    logic [31:0] word;
    logic        counts;
    mismatches = 0;
    steady     = 1'b0;
    foreach (model_regs[i]) model_regs[i] = '0;
    model_pc      = '0;
    model_halted  = 1'b0;
    model_pending = 1'b0;
    model_target  = '0;
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    in_opcode_i      <= KIND_INSTR;
    in_instruction_i <= '0;
    in_fill_data_i   <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Register 5 ends up all ones plus all ones, so the load jumps to the top of the
    // address space and the two spare opcodes wrap the counter back to zero.
    directed_rows = '{
      '{KIND_FILL,  32'h0, 32'hFFFF_FFFF, 1'b1, pinned_result(REQ_NONE, 0, 0, 0, 0, 1'b0)},
      '{KIND_INSTR, abc_word(OP_CMOV, 1, 7, 2), 32'h0, 1'b1,
        pinned_result(REQ_NONE, 0, 0, 0, 1, 1'b0)},
      '{KIND_INSTR, abc_word(OP_DIV, 0, 1, 2), 32'h0, 1'b1,
        pinned_result(REQ_DIVF, 0, 0, 0, 2, 1'b0)},
      '{KIND_INSTR, {OP_LIMM, 3'd1, 25'h1FF_FFFF}, 32'h0, 1'b0, '0},
      '{KIND_INSTR, {OP_LIMM, 3'd7, 25'h0AB_CDEF}, 32'h0, 1'b0, '0},
      '{KIND_INSTR, abc_word(OP_NAND, 3, 0, 0), 32'h0, 1'b0, '0},
      '{KIND_INSTR, abc_word(OP_IN, 0, 0, 4), 32'h0, 1'b1,
        pinned_result(REQ_IN, 0, 0, 0, 6, 1'b1)},
      '{KIND_INSTR, abc_word(OP_ADD, 0, 3, 3), 32'h0, 1'b1,
        pinned_result(REQ_NONE, 0, 0, 0, 6, 1'b1)},
      '{KIND_FILL,  32'h0, 32'hFFFF_FFFF, 1'b1, pinned_result(REQ_NONE, 0, 0, 0, 6, 1'b0)},
      '{KIND_INSTR, abc_word(OP_ADD, 5, 3, 4), 32'h0, 1'b0, '0},
      '{KIND_INSTR, abc_word(OP_MUL, 6, 3, 3), 32'h0, 1'b0, '0},
      '{KIND_INSTR, abc_word(OP_DIV, 0, 3, 6), 32'h0, 1'b0, '0},
      '{KIND_INSTR, abc_word(OP_DIV, 2, 1, 3), 32'h0, 1'b0, '0},
      '{KIND_INSTR, abc_word(OP_OUT, 0, 0, 3), 32'h0, 1'b1,
        pinned_result(REQ_OUT, 0, 0, 32'hFFFF_FFFF, 11, 1'b0)},
      '{KIND_INSTR, abc_word(OP_READ, 2, 1, 3), 32'h0, 1'b0, '0},
      '{KIND_FILL,  32'h0, 32'h8000_0001, 1'b0, '0},
      '{KIND_INSTR, abc_word(OP_WRITE, 5, 1, 2), 32'h0, 1'b0, '0},
      '{KIND_INSTR, abc_word(OP_MAP, 0, 6, 2), 32'h0, 1'b0, '0},
      '{KIND_FILL,  32'h0, 32'h0000_0003, 1'b0, '0},
      '{KIND_INSTR, abc_word(OP_UNMAP, 0, 0, 6), 32'h0, 1'b0, '0},
      '{KIND_INSTR, abc_word(OP_CMOV, 0, 7, 6), 32'h0, 1'b0, '0},
      '{KIND_INSTR, {OP_LIMM, 3'd0, 25'h0}, 32'h0, 1'b0, '0},
      '{KIND_INSTR, abc_word(OP_LOAD, 0, 0, 5), 32'h0, 1'b1,
        pinned_result(REQ_LOAD, 0, 0, 0, 32'hFFFF_FFFE, 1'b0)},
      '{KIND_INSTR, 32'hE123_4567, 32'h0, 1'b0, '0},
      '{KIND_INSTR, 32'hF0F0_F0F0, 32'h0, 1'b1, pinned_result(REQ_NONE, 0, 0, 0, 0, 1'b0)}
    };
    foreach (directed_rows[i])
      send_request(directed_rows[i].kind, directed_rows[i].word, directed_rows[i].fill,
                   directed_rows[i].pinned, directed_rows[i].want);

    // Mostly well-formed traffic: fills follow the requests that wait for them, with
    // stray instructions and fills mixed in that the core must ignore.
    useful = 0;
    while (useful < ITEM_COUNT) begin
      steady = (useful >= 700) && (useful < 1000);
      if (model_pending) begin
        kind = ($urandom_range(99) < 85) ? KIND_FILL : KIND_INSTR;
        word = $urandom();
      end else if ($urandom_range(99) < 6) begin
        kind = KIND_FILL;
        word = $urandom();
      end else begin
        kind = KIND_INSTR;
        op = 4'($urandom_range(15));
        if (op == OP_HALT) op = OP_LIMM;
        word = {op, 28'($urandom())};
      end
      counts = model_pending ? (kind == KIND_FILL) : (kind == KIND_INSTR);
      send_request(kind, word, pick_fill(), 1'b0, '0);
      if (counts) useful++;
    end
    steady = 1'b0;

    if (model_pending) send_request(KIND_FILL, $urandom(), pick_fill(), 1'b0, '0);
    send_request(KIND_INSTR, {OP_HALT, 28'($urandom())}, $urandom(), 1'b0, '0);
    repeat (6) send_request(kind_e'($urandom_range(1)), $urandom(), $urandom(), 1'b0, '0);
    in_valid_i <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> files.f
rtl/um32_pkg.sv
rtl/um32_div.sv
rtl/um32_ctrl.sv
rtl/um32_dp.sv
rtl/um32_instruction_execute_core.sv
rtl/um32_checker.sv
bench/um32_instruction_execute_core_tb.sv
